// ===== hdl/brb_pkg.sv =====
package brb_pkg;

  localparam int DEPTH     = 256;
  localparam int MAX_BURST = 64;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CNT_W     = IDX_W + 1;
  localparam int BURST_W   = $clog2(MAX_BURST + 1);
  localparam int CFG_W     = 4;
  localparam int DATA_W    = 8;

  localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(IDX_W);

  typedef enum logic [2:0] {
    CMD_PUSH   = 3'd0,
    CMD_POP    = 3'd1,
    CMD_DELETE = 3'd2,
    CMD_DMA    = 3'd3,
    CMD_STATUS = 3'd4
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_BURST
  } state_t;

  typedef struct packed {
    logic              byte_valid;
    logic              last;
    logic              accepted;
    logic [CNT_W-1:0]  call_total;
    logic [CNT_W-1:0]  deleted_count;
    logic [CNT_W-1:0]  dma_count;
    logic [IDX_W-1:0]  dma_start;
    logic [CNT_W-1:0]  fill_level;
  } beat_t;

  typedef struct packed {
    logic  valid;
    beat_t beat;
  } issue_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_byte;
    beat_t             beat;
  } result_t;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [IDX_W-1:0]  raddr;
  } mem_req_t;

endpackage

// ===== hdl/brb_store.sv =====
module brb_store (
  input  logic                      clk,
  input  brb_pkg::mem_req_t         req,
  output logic [brb_pkg::DATA_W-1:0] rdata
);
  import brb_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

// ===== hdl/brb_ctrl.sv =====
module brb_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [2:0]                 cmd,
  input  logic [brb_pkg::DATA_W-1:0] data,
  input  logic                       last_of_call,
  input  logic [brb_pkg::CNT_W-1:0]  count,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [brb_pkg::CFG_W-1:0]  size_log2,
  input  logic                       credit,
  output brb_pkg::mem_req_t          req,
  output brb_pkg::issue_t            issue
);
  import brb_pkg::*;

  state_t             state, state_next;
  logic [IDX_W-1:0]   write_index, write_index_next;
  logic [IDX_W-1:0]   read_index, read_index_next;
  logic [CNT_W-1:0]   level, level_next;
  logic [CNT_W-1:0]   dma_pending, dma_pending_next;
  logic [CNT_W-1:0]   call_count, call_count_next;
  logic [BURST_W-1:0] rem, rem_next;
  logic [CFG_W-1:0]   size_sel;

  logic               accept;
  logic               cfg_write;
  logic [CFG_W-1:0]   size_exp;
  logic [CNT_W-1:0]   size;
  logic [IDX_W-1:0]   mask;
  logic [IDX_W-1:0]   read_inc;
  logic [CNT_W-1:0]   pop_lim;
  logic [BURST_W-1:0] take;
  logic [CNT_W-1:0]   del_req;
  logic [CNT_W-1:0]   del;
  logic [CNT_W-1:0]   run;
  logic [CNT_W-1:0]   call_inc;

  assign cfg_ready = (state == ST_IDLE);
  assign cfg_write = cfg_valid && cfg_ready;
  assign in_stall  = (state != ST_IDLE) || !credit;
  assign accept    = in_valid && !in_stall;

  always_comb begin
    if (size_sel == '0) begin
      size_exp = CFG_W'(1);
    end else if (size_sel > CFG_W'(IDX_W)) begin
      size_exp = CFG_W'(IDX_W);
    end else begin
      size_exp = size_sel;
    end
    size     = CNT_W'(1) << size_exp;
    mask     = IDX_W'(size - CNT_W'(1));
    read_inc = (read_index + IDX_W'(1)) & mask;
    pop_lim  = (count < level) ? count : level;
    take     = (pop_lim > CNT_W'(MAX_BURST)) ? BURST_W'(MAX_BURST) : BURST_W'(pop_lim);
    del_req  = (dma_pending != '0) ? dma_pending : count;
    del      = (del_req > level) ? level : del_req;
    run      = size - CNT_W'(read_index);
    if (run > level) begin
      run = level;
    end
    call_inc = (call_count == '1) ? call_count : call_count + CNT_W'(1);
  end

  always_comb begin
    state_next       = state;
    write_index_next = write_index;
    read_index_next  = read_index;
    level_next       = level;
    dma_pending_next = dma_pending;
    call_count_next  = call_count;
    rem_next         = rem;
    req              = '0;
    issue            = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          issue.valid           = 1'b1;
          issue.beat.last       = 1'b1;
          issue.beat.fill_level = level;
          case (cmd_t'(cmd))
            CMD_PUSH: begin
              if (level < size) begin
                req.we                = 1'b1;
                req.waddr             = write_index;
                req.wdata             = data;
                write_index_next      = (write_index + IDX_W'(1)) & mask;
                level_next            = level + CNT_W'(1);
                issue.beat.accepted   = 1'b1;
                issue.beat.fill_level = level + CNT_W'(1);
                call_count_next       = call_inc;
              end
              if (last_of_call) begin
                issue.beat.call_total = (level < size) ? call_inc : call_count;
                call_count_next       = '0;
              end
            end
            CMD_POP: begin
              if (take != '0) begin
                req.re                = 1'b1;
                req.raddr             = read_index;
                read_index_next       = read_inc;
                level_next            = level - CNT_W'(take);
                issue.beat.byte_valid = 1'b1;
                issue.beat.last       = (take == BURST_W'(1));
                issue.beat.fill_level = level - CNT_W'(take);
                rem_next              = take - BURST_W'(1);
                if (take != BURST_W'(1)) begin
                  state_next = ST_BURST;
                end
              end
            end
            CMD_DELETE: begin
              dma_pending_next         = '0;
              level_next               = level - del;
              read_index_next          = (read_index + IDX_W'(del)) & mask;
              issue.beat.deleted_count = del;
              issue.beat.fill_level    = level - del;
            end
            CMD_DMA: begin
              dma_pending_next     = run;
              issue.beat.dma_count = run;
              issue.beat.dma_start = read_index;
            end
            default: begin
            end
          endcase
        end
      end
      ST_BURST: begin
        if (credit) begin
          req.re                = 1'b1;
          req.raddr             = read_index;
          read_index_next       = read_inc;
          issue.valid           = 1'b1;
          issue.beat.byte_valid = 1'b1;
          issue.beat.last       = (rem == BURST_W'(1));
          issue.beat.fill_level = level;
          rem_next              = rem - BURST_W'(1);
          if (rem == BURST_W'(1)) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size_sel    <= SIZE_RESET;
      write_index <= '0;
      read_index  <= '0;
      level       <= '0;
      dma_pending <= '0;
      call_count  <= '0;
      rem         <= '0;
    end else if (cfg_write) begin
      size_sel    <= size_log2;
      write_index <= '0;
      read_index  <= '0;
      level       <= '0;
      dma_pending <= '0;
      call_count  <= '0;
    end else begin
      write_index <= write_index_next;
      read_index  <= read_index_next;
      level       <= level_next;
      dma_pending <= dma_pending_next;
      call_count  <= call_count_next;
      rem         <= rem_next;
    end
  end

endmodule

// ===== hdl/brb_outq.sv =====
module brb_outq (
  input  logic                       clk,
  input  logic                       rst,
  input  brb_pkg::issue_t            issue,
  input  logic [brb_pkg::DATA_W-1:0] rdata,
  output logic                       credit,
  output logic                       out_valid,
  input  logic                       out_stall,
  output brb_pkg::result_t           result
);
  import brb_pkg::*;

  logic        s1_valid;
  beat_t       s1_beat;
  result_t     q [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  cnt, cnt_next;
  logic [2:0]  occ;
  logic        deq;
  result_t     entry;

  assign deq       = out_valid && !out_stall;
  assign out_valid = (cnt != 2'd0);
  assign result    = q[rd_ptr];
  assign occ       = 3'(cnt) + 3'(s1_valid) - 3'(deq);
  assign credit    = (occ < 3'd2);
  assign cnt_next  = 2'(3'(cnt) + 3'(s1_valid) - 3'(deq));

  always_comb begin
    entry.beat      = s1_beat;
    entry.read_byte = s1_beat.byte_valid ? rdata : '0;
  end

  always_ff @(posedge clk) begin
    s1_beat <= issue.beat;
    if (s1_valid) begin
      q[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      wr_ptr   <= 1'b0;
      rd_ptr   <= 1'b0;
      cnt      <= 2'd0;
    end else begin
      s1_valid <= issue.valid;
      cnt      <= cnt_next;
      if (s1_valid) begin
        wr_ptr <= !wr_ptr;
      end
      if (deq) begin
        rd_ptr <= !rd_ptr;
      end
    end
  end

endmodule

// ===== hdl/byte_ring_buffer_with_dma_release.sv =====
// Byte ring buffer with DMA release.
// Input channel (in_valid/in_stall) carries one command beat: cmd, data,
// last_of_call, count. Output channel (out_valid/out_stall) returns result
// beats; every command gives one beat, a pop gives one beat per byte (up to
// 64) with last set on the final one, and every beat carries fill_level.
// Config channel (cfg_valid/cfg_ready) writes size_log2 and empties the
// buffer; it is taken only while no pop burst is running.
// Each result passes the synchronous store read and then the output queue
// before it appears on the output channel.
// Push, delete, dma prepare and status may follow back to back while the
// output queue has room; a pop holds the input until its burst ends, one
// store read per cycle via the single read port while the queue has room.
// When the receiver stalls, a two-beat output queue absorbs beats in flight
// and in_stall rises (or the burst pauses) until space frees up.
// Reset clears indices, level, pending DMA run and call count and sets
// size_log2 to 8; store contents are undefined until written.
module byte_ring_buffer_with_dma_release (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [2:0]                 cmd,
  input  logic [brb_pkg::DATA_W-1:0] data,
  input  logic                       last_of_call,
  input  logic [brb_pkg::CNT_W-1:0]  count,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [brb_pkg::CFG_W-1:0]  size_log2,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [brb_pkg::DATA_W-1:0] read_byte,
  output logic                       byte_valid,
  output logic                       last,
  output logic                       accepted,
  output logic [brb_pkg::CNT_W-1:0]  call_total,
  output logic [brb_pkg::CNT_W-1:0]  deleted_count,
  output logic [brb_pkg::CNT_W-1:0]  dma_count,
  output logic [brb_pkg::IDX_W-1:0]  dma_start,
  output logic [brb_pkg::CNT_W-1:0]  fill_level
);
  import brb_pkg::*;

  mem_req_t          req;
  issue_t            issue;
  logic [DATA_W-1:0] rdata;
  logic              credit;
  result_t           result;

  brb_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .data         (data),
    .last_of_call (last_of_call),
    .count        (count),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .size_log2    (size_log2),
    .credit       (credit),
    .req          (req),
    .issue        (issue)
  );

  brb_store u_store (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  brb_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .issue     (issue),
    .rdata     (rdata),
    .credit    (credit),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .result    (result)
  );

  assign read_byte     = result.read_byte;
  assign byte_valid    = result.beat.byte_valid;
  assign last          = result.beat.last;
  assign accepted      = result.beat.accepted;
  assign call_total    = result.beat.call_total;
  assign deleted_count = result.beat.deleted_count;
  assign dma_count     = result.beat.dma_count;
  assign dma_start     = result.beat.dma_start;
  assign fill_level    = result.beat.fill_level;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import brb_pkg::*;

  localparam int CMD_TOP     = 7;
  localparam int CALL_MAX    = (1 << CNT_W) - 1;
  localparam int IDLE_PCT    = 19;
  localparam int HOLD_AT     = 30;
  localparam int HOLD_CYCLES = 120;
  localparam int SETTLE      = 8;
  localparam int DRAIN_LIMIT = 20000;

  typedef struct {
    logic [2:0]        op;
    logic [DATA_W-1:0] byte_in;
    logic              end_call;
    logic [CNT_W-1:0]  req;
  } ring_cmd_t;

  typedef struct {
    logic [DATA_W-1:0] read_byte;
    logic              byte_valid;
    logic              last;
    logic              accepted;
    logic [CNT_W-1:0]  call_total;
    logic [CNT_W-1:0]  deleted_count;
    logic [CNT_W-1:0]  dma_count;
    logic [IDX_W-1:0]  dma_start;
    logic [CNT_W-1:0]  fill_level;
  } ring_beat_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [2:0]        cmd = CMD_STATUS;
  logic [DATA_W-1:0] data = '0;
  logic              last_of_call = 1'b0;
  logic [CNT_W-1:0]  count = '0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_W-1:0]  size_log2 = SIZE_RESET;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [DATA_W-1:0] read_byte;
  logic              byte_valid;
  logic              last;
  logic              accepted;
  logic [CNT_W-1:0]  call_total;
  logic [CNT_W-1:0]  deleted_count;
  logic [CNT_W-1:0]  dma_count;
  logic [IDX_W-1:0]  dma_start;
  logic [CNT_W-1:0]  fill_level;

  // shadow ring state
  logic [DATA_W-1:0] ring_mem [DEPTH];
  int wr_pos, rd_pos, held, dma_run, call_bytes, size_code;

  ring_cmd_t  pending_cmds[$];
  ring_beat_t beats_due[$];

  int  errors = 0;
  int  in_beats = 0;
  int  out_beats = 0;
  int  cfg_writes = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  bit  in_fire = 1'b0;
  wire quiet = in_beats >= 120 && in_beats < 200;

  byte_ring_buffer_with_dma_release dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int ring_span(int code);
    int s, span;
    s = code;
    if (s < 1) s = 1;
    span = 1 << s;
    while (span > DEPTH) span = span >> 1;
    return span;
  endfunction

  task automatic ring_config(int code);
    size_code = code;
    wr_pos = 0;
    rd_pos = 0;
    held = 0;
    dma_run = 0;
    call_bytes = 0;
  endtask

  task automatic ring_predict(ring_cmd_t c);
    ring_beat_t b;
    int span, mask, take, rel, run, k;
    span = ring_span(size_code);
    mask = span - 1;
    b = '{default: 0};
    if (c.op == CMD_POP) begin
      take = c.req;
      if (take > held) take = held;
      if (take > MAX_BURST) take = MAX_BURST;
      held -= take;
      if (take == 0) begin
        b.last = 1'b1;
        b.fill_level = CNT_W'(held);
        beats_due.push_back(b);
      end
      for (k = 0; k < take; k++) begin
        b.read_byte = ring_mem[rd_pos];
        b.byte_valid = 1'b1;
        b.last = (k == take - 1);
        b.fill_level = CNT_W'(held);
        beats_due.push_back(b);
        rd_pos = (rd_pos + 1) & mask;
      end
    end else begin
      case (c.op)
        CMD_PUSH: begin
          if (held < span) begin
            ring_mem[wr_pos] = c.byte_in;
            wr_pos = (wr_pos + 1) & mask;
            held++;
            b.accepted = 1'b1;
            if (call_bytes < CALL_MAX) call_bytes++;
          end
          if (c.end_call) begin
            b.call_total = CNT_W'(call_bytes);
            call_bytes = 0;
          end
        end
        CMD_DELETE: begin
          rel = (dma_run != 0) ? dma_run : c.req;
          dma_run = 0;
          if (rel > held) rel = held;
          held -= rel;
          rd_pos = (rd_pos + rel) & mask;
          b.deleted_count = CNT_W'(rel);
        end
        CMD_DMA: begin
          run = span - rd_pos;
          if (run > held) run = held;
          dma_run = run;
          b.dma_count = CNT_W'(run);
          b.dma_start = IDX_W'(rd_pos);
        end
        default: ;
      endcase
      b.last = 1'b1;
      b.fill_level = CNT_W'(held);
      beats_due.push_back(b);
    end
  endtask

  task automatic flag_mismatch(string msg);
    errors++;
    if (errors <= 40) $display("MISMATCH: %s", msg);
  endtask

  task automatic check_field(string name, logic [CNT_W-1:0] got, logic [CNT_W-1:0] want);
    if (got !== want)
      flag_mismatch($sformatf("beat %0d %s got %0h expected %0h", out_beats, name, got, want));
  endtask

  task automatic add_item(logic [2:0] op, logic [DATA_W-1:0] d, logic lc, logic [CNT_W-1:0] n);
    ring_cmd_t c;
    c = '{op, d, lc, n};
    pending_cmds.push_back(c);
  endtask

  task automatic add_pushes(int n, logic end_call);
    int k;
    for (k = 0; k < n; k++)
      add_item(CMD_PUSH, DATA_W'($urandom), end_call && k == n - 1, CNT_W'($urandom));
  endtask

  task automatic queue_random(int n);
    int left, pick, len;
    left = n;
    while (left > 0) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        len = $urandom_range(1, 8);
        add_pushes(len, $urandom_range(9) != 0);
        left -= len;
      end else if (pick < 60) begin
        add_item(CMD_POP, DATA_W'($urandom), 1'($urandom),
                 CNT_W'(($urandom_range(7) == 0) ? $urandom_range(0, 256) :
                                                   $urandom_range(0, 12)));
        left--;
      end else if (pick < 75) begin
        // reserve a run, maybe pop past it, then release
        add_item(CMD_DMA, DATA_W'($urandom), 1'($urandom), CNT_W'($urandom_range(0, 256)));
        left--;
        if ($urandom_range(2) == 0) begin
          add_item(CMD_POP, DATA_W'($urandom), 1'($urandom), CNT_W'($urandom_range(0, 6)));
          left--;
        end
        add_item(CMD_DELETE, DATA_W'($urandom), 1'($urandom),
                 CNT_W'($urandom_range(0, 256)));
        left--;
      end else if (pick < 85) begin
        add_item(CMD_DELETE, DATA_W'($urandom), 1'($urandom),
                 CNT_W'(($urandom_range(3) == 0) ? $urandom_range(0, 256) :
                                                   $urandom_range(0, 10)));
        left--;
      end else if (pick < 95) begin
        add_item(3'($urandom_range(CMD_STATUS, CMD_TOP)), DATA_W'($urandom), 1'($urandom),
                 CNT_W'($urandom_range(0, 256)));
        left--;
      end else begin
        add_item(3'($urandom_range(0, CMD_TOP)), DATA_W'($urandom), 1'($urandom),
                 CNT_W'($urandom_range(0, 256)));
        left--;
      end
    end
  endtask

  task automatic drain();
    int waited;
    waited = 0;
    while ((pending_cmds.size() != 0 || in_valid || beats_due.size() != 0) &&
           waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE) @(posedge clk);
    if (beats_due.size() != 0) begin
      flag_mismatch($sformatf("%0d expected results never arrived", beats_due.size()));
      beats_due.delete();
    end
  endtask

  task automatic ring_setup(int code);
    @(negedge clk);
    cfg_valid <= 1'b1;
    size_log2 <= CFG_W'(code);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    ring_config(code);
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // command driver
  always @(negedge clk) begin : drive
    ring_cmd_t c;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (pending_cmds.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
        c = pending_cmds.pop_front();
        in_valid <= 1'b1;
        cmd <= c.op;
        data <= c.byte_in;
        last_of_call <= c.end_call;
        count <= c.req;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver stall, with one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (!hold_done && in_beats >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && $urandom_range(99) < IDLE_PCT;
    end
  end

  // accept commands into the predictor, check result beats
  always @(posedge clk) begin : watch
    ring_cmd_t  c;
    ring_beat_t want;
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        c = '{cmd, data, last_of_call, count};
        ring_predict(c);
        in_beats++;
      end
      if (out_valid && !out_stall) begin
        if (beats_due.size() == 0) begin
          flag_mismatch($sformatf("beat %0d arrived with nothing expected", out_beats));
        end else begin
          want = beats_due.pop_front();
          check_field("read_byte", read_byte, want.read_byte);
          check_field("byte_valid", byte_valid, want.byte_valid);
          check_field("last", last, want.last);
          check_field("accepted", accepted, want.accepted);
          check_field("call_total", call_total, want.call_total);
          check_field("deleted_count", deleted_count, want.deleted_count);
          check_field("dma_count", dma_count, want.dma_count);
          check_field("dma_start", dma_start, want.dma_start);
          check_field("fill_level", fill_level, want.fill_level);
        end
        out_beats++;
      end
    end
  end

  initial begin : main
    int codes[$];
    ring_config(SIZE_RESET);
    codes = '{1, 0, 2, 15, 3, 9, 5, 8, 4};
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // directed, full 256-byte ring
    add_item(CMD_STATUS, 8'h00, 1'b0, 9'd0);
    add_item(CMD_POP, 8'h00, 1'b0, 9'd5);
    add_item(CMD_DELETE, 8'h00, 1'b0, 9'd10);
    add_item(CMD_DMA, 8'h00, 1'b0, 9'd0);
    add_item(CMD_PUSH, 8'h00, 1'b0, 9'd0);
    add_item(CMD_PUSH, 8'hff, 1'b0, 9'h1ff);
    add_item(CMD_PUSH, 8'ha5, 1'b1, 9'd0);
    add_item(CMD_PUSH, 8'h5a, 1'b1, 9'd0);
    add_item(CMD_POP, 8'h00, 1'b0, 9'd0);
    add_item(CMD_POP, 8'h00, 1'b0, 9'd2);
    add_item(CMD_DMA, 8'h00, 1'b0, 9'd0);
    add_item(CMD_POP, 8'h00, 1'b0, 9'd1);
    add_item(CMD_DELETE, 8'h00, 1'b0, 9'd0);
    add_item(CMD_PUSH, 8'h3c, 1'b0, 9'd0);
    add_item(CMD_PUSH, 8'hc3, 1'b1, 9'd0);
    add_item(CMD_DELETE, 8'h00, 1'b0, 9'd256);
    add_item(3'(CMD_STATUS + 1), 8'hff, 1'b1, 9'h1ff);
    add_item(3'(CMD_STATUS + 2), 8'h00, 1'b0, 9'd256);
    add_item(3'(CMD_TOP), 8'h55, 1'b1, 9'd7);
    add_item(CMD_PUSH, 8'h81, 1'b1, 9'd0);
    add_item(CMD_POP, 8'h00, 1'b0, 9'd256);
    add_item(CMD_POP, 8'h00, 1'b0, 9'd256);
    drain();

    // 8-byte ring pushed past the top in one call: drops, then wrap
    ring_setup(3);
    add_pushes(12, 1'b0);
    add_item(CMD_PUSH, 8'h77, 1'b1, 9'd0);
    add_item(CMD_POP, 8'h00, 1'b0, 9'd5);
    add_item(CMD_DMA, 8'h00, 1'b0, 9'd0);
    add_item(CMD_POP, 8'h00, 1'b0, 9'd2);
    add_item(CMD_DELETE, 8'h00, 1'b0, 9'd3);
    add_pushes(5, 1'b1);
    add_item(CMD_DMA, 8'h00, 1'b0, 9'd0);
    add_item(CMD_POP, 8'h00, 1'b0, 9'd256);
    drain();

    foreach (codes[i]) begin
      ring_setup(codes[i]);
      if (codes[i] == 1) add_pushes(3, 1'b1);
      queue_random(22);
      drain();
    end

    $display("%0d command beats sent, %0d result beats checked", in_beats, out_beats);
    $display("%0d size writes covering 2..256 byte rings and out-of-range codes", cfg_writes);
    if (errors == 0) begin
      $display("byte_ring_buffer_with_dma_release verification clean");
    end else begin
      $display("byte_ring_buffer_with_dma_release verification failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("byte_ring_buffer_with_dma_release verification failed");
    $finish;
  end

endmodule

// ===== byte_ring_buffer_with_dma_release.f =====
hdl/brb_pkg.sv
hdl/brb_store.sv
hdl/brb_ctrl.sv
hdl/brb_outq.sv
hdl/byte_ring_buffer_with_dma_release.sv
test/tb.sv
